// ===== sv/cascade_incremental_position_speed_pid_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cascaded position/speed PID block
// Shared property forms, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef CASCADE_INCREMENTAL_POSITION_SPEED_PID_DEFINES_SVH
`define CASCADE_INCREMENTAL_POSITION_SPEED_PID_DEFINES_SVH

// same-cycle implication
`define CIPSP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CIPSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cipsp_pkg.sv =====
// ----------------------------------------------------------------------------
// cipsp_pkg
// Types and fixed constants of the cascaded position/speed PID block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cipsp_pkg;

  localparam int CFG_W    = 16;
  localparam int LIMIT_W  = 15;
  localparam int IDX_W    = 4;
  localparam int GAIN_W   = 19;
  localparam int OUT_W    = 16;
  localparam int IERR_W   = 18;
  localparam int TGT_W    = 32;
  localparam int ANG_W    = 13;
  localparam int TURN_W   = 18;
  localparam int SPD_W    = 16;
  localparam int S_DATA_W = 80;
  localparam int M_DATA_W = 32;

  localparam logic [IDX_W-1:0] REG_OUTER_KP    = 4'd0;
  localparam logic [IDX_W-1:0] REG_OUTER_KI    = 4'd1;
  localparam logic [IDX_W-1:0] REG_OUTER_KD    = 4'd2;
  localparam logic [IDX_W-1:0] REG_OUTER_LIMIT = 4'd3;
  localparam logic [IDX_W-1:0] REG_INNER_KP    = 4'd4;
  localparam logic [IDX_W-1:0] REG_INNER_KI    = 4'd5;
  localparam logic [IDX_W-1:0] REG_INNER_KD    = 4'd6;
  localparam logic [IDX_W-1:0] REG_INNER_LIMIT = 4'd7;

  // multiply steps: bit 0 selects the high half of the operand,
  // bits 2:1 select the term
  typedef logic [2:0] step_t;
  localparam step_t STEP_FIRST = 3'd0;
  localparam step_t STEP_LAST  = 3'd5;

  localparam logic [1:0] TERM_NOW    = 2'd0;
  localparam logic [1:0] TERM_LAST   = 2'd1;
  localparam logic [1:0] TERM_BEFORE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_MUL,
    ST_DRAIN,
    ST_SAT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic  err_load;
    logic  issue;
    step_t step;
    logic  add;
    logic  sat;
    logic  inner;
    logic  out_load;
  } ctl_t;

endpackage

// ===== sv/cipsp_mac.sv =====
// ----------------------------------------------------------------------------
// cipsp_mac
// Shared multiply-accumulate unit: one half-width partial product per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cipsp_mac #(
  parameter int OP_W  = 34,
  parameter int ACC_W = 57
) (
  input  logic                            clk,
  input  logic                            load,
  input  logic signed [ACC_W-1:0]         init,
  input  logic                            issue,
  input  logic                            hi,
  input  logic                            add,
  input  logic signed [OP_W-1:0]          operand,
  input  logic signed [cipsp_pkg::GAIN_W-1:0] gain,
  output logic signed [ACC_W-1:0]         acc
);
  import cipsp_pkg::*;

  localparam int LO_W   = (OP_W + 1) / 2;
  localparam int HI_W   = OP_W - LO_W;
  localparam int PROD_W = LO_W + 1 + GAIN_W;

  logic signed [LO_W:0]       part;
  logic signed [PROD_W-1:0]   product;
  logic signed [ACC_W-1:0]    prod_ext;
  logic signed [ACC_W-1:0]    prod;

  always_comb begin
    if (hi) begin
      part = {{(LO_W + 1 - HI_W){operand[OP_W-1]}}, operand[OP_W-1:LO_W]};
    end else begin
      part = {1'b0, operand[LO_W-1:0]};
    end
    product  = part * gain;
    prod_ext = {{(ACC_W - PROD_W){product[PROD_W-1]}}, product};
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      prod <= hi ? (prod_ext <<< LO_W) : prod_ext;
    end
    if (load) begin
      acc <= init;
    end else if (add) begin
      acc <= acc + prod;
    end
  end

endmodule

// ===== sv/cipsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// cipsp_ctrl
// Sequencer: error, six multiply steps, drain and saturate for each loop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cipsp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  input  logic            out_free,
  output logic            s_tready,
  output cipsp_pkg::ctl_t ctl
);
  import cipsp_pkg::*;

  state_t state, state_next;
  step_t  step, step_next;
  logic   inner, inner_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= STEP_FIRST;
      inner <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      inner <= inner_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    inner_next = inner;
    s_tready   = 1'b0;
    ctl        = '0;
    ctl.step   = step;
    ctl.inner  = inner;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          inner_next = 1'b0;
          state_next = ST_ERR;
        end
      end
      ST_ERR: begin
        ctl.err_load = 1'b1;
        step_next    = STEP_FIRST;
        state_next   = ST_MUL;
      end
      ST_MUL: begin
        ctl.issue = 1'b1;
        ctl.add   = (step != STEP_FIRST);
        if (step == STEP_LAST) begin
          state_next = ST_DRAIN;
        end else begin
          step_next = step + 3'd1;
        end
      end
      ST_DRAIN: begin
        ctl.add    = 1'b1;
        state_next = ST_SAT;
      end
      ST_SAT: begin
        ctl.sat = 1'b1;
        if (inner) begin
          state_next = ST_DONE;
        end else begin
          inner_next = 1'b1;
          state_next = ST_ERR;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          ctl.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/cascade_incremental_position_speed_pid.sv =====
// ----------------------------------------------------------------------------
// cascade_incremental_position_speed_pid
// Cascaded incremental PID: position loop driving a speed loop.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one transaction per control tick carrying target
//   position, encoder angle, turn count and measured speed.
//   Output stream m_*: one transaction per tick with the saturated speed
//   setpoint and drive command.
//   Config port: cfg_we writes cfg_data into register cfg_index (0..7,
//   higher indexes are ignored). Write only while the block is idle.
//   The outer loop runs first, then the inner loop. Each loop steps through
//   the shared multiplier in order (error, six half-width partial products,
//   drain, saturate); the result is then posted to the output register and
//   only after that does the block accept the next tick.
//   The output register lets the next tick be taken while a result waits;
//   a tick that finishes while the receiver still stalls holds until the
//   output register frees up.
//   Reset clears gains, limits, error history, accumulators and m_tvalid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cascade_incremental_position_speed_pid_defines.svh"

module cascade_incremental_position_speed_pid #(
  parameter int COUNTS_PER_TURN = 8192,
  parameter int FRAC_BITS       = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // target_position[31:0], encoder_angle[44:32], turn_count[62:45],
  // speed_feedback[78:63], zero pad [79]
  input  logic [cipsp_pkg::S_DATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // speed_setpoint[15:0], drive_command[31:16]
  output logic [cipsp_pkg::M_DATA_W-1:0]    m_tdata,
  input  logic                              cfg_we,
  input  logic [cipsp_pkg::IDX_W-1:0]       cfg_index,
  input  logic [cipsp_pkg::CFG_W-1:0]       cfg_data
);
  import cipsp_pkg::*;

  localparam int CPT_BITS = $clog2(COUNTS_PER_TURN);
  localparam int POS_W    = ((TURN_W + CPT_BITS) > ANG_W ? (TURN_W + CPT_BITS) : ANG_W) + 2;
  localparam int ERR_W    = (POS_W > TGT_W ? POS_W : TGT_W) + 1;
  localparam int ACC_W    = ERR_W + GAIN_W + 4;
  localparam int AC_W     = OUT_W + FRAC_BITS;

  localparam logic signed [ERR_W-1:0] CPT_K     = ERR_W'(COUNTS_PER_TURN);
  localparam logic [AC_W-1:0]         FRAC_MASK = {{OUT_W{1'b0}}, {FRAC_BITS{1'b1}}};

  ctl_t ctl;
  logic out_free;

  // configuration
  logic [CFG_W-1:0]   outer_kp, outer_ki, outer_kd;
  logic [CFG_W-1:0]   inner_kp, inner_ki, inner_kd;
  logic [LIMIT_W-1:0] outer_limit, inner_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      outer_kp    <= '0;
      outer_ki    <= '0;
      outer_kd    <= '0;
      outer_limit <= '0;
      inner_kp    <= '0;
      inner_ki    <= '0;
      inner_kd    <= '0;
      inner_limit <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OUTER_KP:    outer_kp    <= cfg_data;
        REG_OUTER_KI:    outer_ki    <= cfg_data;
        REG_OUTER_KD:    outer_kd    <= cfg_data;
        REG_OUTER_LIMIT: outer_limit <= cfg_data[LIMIT_W-1:0];
        REG_INNER_KP:    inner_kp    <= cfg_data;
        REG_INNER_KI:    inner_ki    <= cfg_data;
        REG_INNER_KD:    inner_kd    <= cfg_data;
        REG_INNER_LIMIT: inner_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // input capture
  logic signed [TGT_W-1:0]  target_position;
  logic [ANG_W-1:0]         encoder_angle;
  logic signed [TURN_W-1:0] turn_count;
  logic signed [SPD_W-1:0]  speed_feedback;

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      target_position <= s_tdata[31:0];
      encoder_angle   <= s_tdata[44:32];
      turn_count      <= s_tdata[62:45];
      speed_feedback  <= s_tdata[78:63];
    end
  end

  // loop state
  logic signed [ERR_W-1:0]  outer_err_last, outer_err_before;
  logic signed [IERR_W-1:0] inner_err_last, inner_err_before;
  logic signed [AC_W-1:0]   outer_accum, inner_accum;
  logic signed [ERR_W-1:0]  cur_err;

  // truncate toward zero
  logic [AC_W-1:0]         outer_adj, inner_adj;
  logic signed [OUT_W-1:0] speed_setpoint, drive_command;

  always_comb begin
    outer_adj      = outer_accum + (outer_accum[AC_W-1] ? FRAC_MASK : '0);
    inner_adj      = inner_accum + (inner_accum[AC_W-1] ? FRAC_MASK : '0);
    speed_setpoint = outer_adj[AC_W-1:FRAC_BITS];
    drive_command  = inner_adj[AC_W-1:FRAC_BITS];
  end

  // error formation
  logic signed [ERR_W-1:0]  position, outer_err, err_sel;
  logic signed [IERR_W-1:0] inner_err;

  always_comb begin
    position  = {{(ERR_W - ANG_W){1'b0}}, encoder_angle}
              + {{(ERR_W - TURN_W){turn_count[TURN_W-1]}}, turn_count} * CPT_K;
    outer_err = {{(ERR_W - TGT_W){target_position[TGT_W-1]}}, target_position} - position;
    inner_err = {{(IERR_W - OUT_W){speed_setpoint[OUT_W-1]}}, speed_setpoint}
              - {{(IERR_W - SPD_W){speed_feedback[SPD_W-1]}}, speed_feedback};
    err_sel   = ctl.inner ? {{(ERR_W - IERR_W){inner_err[IERR_W-1]}}, inner_err} : outer_err;
  end

  // operand and gain selection for the shared unit
  logic [CFG_W-1:0]         kp, ki, kd;
  logic signed [GAIN_W-1:0] g_now, g_last, g_before, gain;
  logic signed [ERR_W-1:0]  e_last, e_before, operand;
  logic signed [ACC_W-1:0]  init;

  always_comb begin
    kp       = ctl.inner ? inner_kp : outer_kp;
    ki       = ctl.inner ? inner_ki : outer_ki;
    kd       = ctl.inner ? inner_kd : outer_kd;
    g_now    = GAIN_W'(kp) + GAIN_W'(ki) + GAIN_W'(kd);
    g_last   = '0 - (GAIN_W'(kp) + (GAIN_W'(kd) << 1));
    g_before = GAIN_W'(kd);
    e_last   = ctl.inner ? {{(ERR_W - IERR_W){inner_err_last[IERR_W-1]}}, inner_err_last}
                         : outer_err_last;
    e_before = ctl.inner ? {{(ERR_W - IERR_W){inner_err_before[IERR_W-1]}}, inner_err_before}
                         : outer_err_before;
    case (ctl.step[2:1])
      TERM_NOW: begin
        operand = cur_err;
        gain    = g_now;
      end
      TERM_LAST: begin
        operand = e_last;
        gain    = g_last;
      end
      TERM_BEFORE: begin
        operand = e_before;
        gain    = g_before;
      end
      default: begin
        operand = cur_err;
        gain    = g_now;
      end
    endcase
    init = ctl.inner ? {{(ACC_W - AC_W){inner_accum[AC_W-1]}}, inner_accum}
                     : {{(ACC_W - AC_W){outer_accum[AC_W-1]}}, outer_accum};
  end

  logic signed [ACC_W-1:0] acc;

  cipsp_mac #(
    .OP_W  (ERR_W),
    .ACC_W (ACC_W)
  ) u_mac (
    .clk     (clk),
    .load    (ctl.err_load),
    .init    (init),
    .issue   (ctl.issue),
    .hi      (ctl.step[0]),
    .add     (ctl.add),
    .operand (operand),
    .gain    (gain),
    .acc     (acc)
  );

  cipsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .out_free (out_free),
    .s_tready (s_tready),
    .ctl      (ctl)
  );

  // saturation
  logic [LIMIT_W-1:0]      limit;
  logic signed [ACC_W-1:0] lim_pos, lim_neg, sat_val;

  always_comb begin
    limit   = ctl.inner ? inner_limit : outer_limit;
    lim_pos = {{(ACC_W - LIMIT_W - FRAC_BITS){1'b0}}, limit, {FRAC_BITS{1'b0}}};
    lim_neg = '0 - lim_pos;
    if (acc > lim_pos) begin
      sat_val = lim_pos;
    end else if (acc < lim_neg) begin
      sat_val = lim_neg;
    end else begin
      sat_val = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.err_load) begin
      cur_err <= err_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outer_err_last   <= '0;
      outer_err_before <= '0;
      inner_err_last   <= '0;
      inner_err_before <= '0;
      outer_accum      <= '0;
      inner_accum      <= '0;
    end else if (ctl.sat) begin
      if (ctl.inner) begin
        inner_accum      <= sat_val[AC_W-1:0];
        inner_err_before <= inner_err_last;
        inner_err_last   <= cur_err[IERR_W-1:0];
      end else begin
        outer_accum      <= sat_val[AC_W-1:0];
        outer_err_before <= outer_err_last;
        outer_err_last   <= cur_err;
      end
    end
  end

  // output register
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      m_tdata <= {drive_command, speed_setpoint};
    end
  end

  `CIPSP_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "tick accepted but block still ready")
  `CIPSP_ASSERT_SAME(a_no_overwrite, ctl.out_load, !m_tvalid || m_tready, "pending result overwritten")
  `CIPSP_ASSERT_SAME(a_out_range, m_tvalid, (m_tdata[15:0] != 16'h8000) && (m_tdata[31:16] != 16'h8000), "output outside symmetric range")

endmodule
